// ----- hdl/ow_pkg.sv -----
// Package for the single-wire bus master: sequence phases and bus timing constants.
// No dependencies; imported by one_wire_bus_master and by the testbench tb.
package ow_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_REC  = 3'd3,
        PH_WRITE    = 3'd4,
        PH_READ     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    localparam int TICK_W = 10;

    localparam logic [TICK_W-1:0] RST_LOW_TICKS    = 10'd480;
    localparam logic [TICK_W-1:0] RST_SAMPLE_TICKS = 10'd70;
    localparam logic [TICK_W-1:0] RST_REC_TICKS    = 10'd410;
    localparam logic [TICK_W-1:0] SLOT_START_TICKS = 10'd2;
    localparam logic [TICK_W-1:0] WR_LOW_END_TICKS = 10'd62;  // start ticks plus 60 hold
    localparam logic [TICK_W-1:0] WR_SLOT_TICKS    = 10'd64;
    localparam logic [TICK_W-1:0] RD_SAMPLE_TICK   = 10'd12;  // 10 ticks after release
    localparam logic [TICK_W-1:0] RD_SLOT_TICKS    = 10'd62;

endpackage

// ----- hdl/one_wire_bus_master.sv -----
// Single-wire bus master: reset, write byte and read byte sequences on one open-drain line.
// Depends on ow_pkg (phase and opcode types, timing constants).
//
// Usage: every input transaction on s_axis is either a start command (reset, write byte,
// read byte) or a tick that stands for one microsecond of bus time and carries the level
// of the line sampled during that tick. Each input transaction produces exactly one result
// transaction on m_axis, giving the line drive for the coming tick, busy, done, presence,
// the shift byte and a rejected flag for a start that arrived while a sequence ran.
// Latency: the result of an item is presented on m_axis the cycle after it is accepted.
// Throughput: one item per cycle while m_axis_tready is high; the sequencer state and the result register both update
// in the accept cycle, so a tick stream at the full clock rate is taken without gaps unless the sink stalls.
// The result register doubles as the skid stage: s_axis_tready stays high while the held
// result is being taken, and drops only while a result waits and m_axis_tready is low;
// no item is lost or dropped during a stall.
// Reset (rst_n low, asynchronous): phase idle, counters, shift byte and presence cleared,
// no result pending.
module one_wire_bus_master
    import ow_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] write_data, [8] line_level, [15:9] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] drive_low, [1] busy_res, [2] done_res,
                                        // [3] presence, [11:4] read_data, [12] rejected,
                                        // [15:13] zero
);

    phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]  slot_ticks_reg, slot_ticks_next;
    logic [2:0]         bit_index_reg, bit_index_next;
    logic [7:0]         shift_byte_reg, shift_byte_next;
    logic               presence_reg, presence_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_data_reg, out_data_next;

    logic               accept;
    opcode_t            opcode;
    logic [7:0]         write_data;
    logic               line_level;
    logic [TICK_W-1:0]  slot_inc;
    logic               done;
    logic               rejected;
    logic               drive_low;

    assign opcode     = opcode_t'(s_axis_tuser);
    assign write_data = s_axis_tdata[7:0];
    assign line_level = s_axis_tdata[8];
    assign slot_inc   = slot_ticks_reg + 1'b1;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // next state of the sequencer for the item at the input
    always_comb
    begin
        phase_next      = phase_reg;
        slot_ticks_next = slot_ticks_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        presence_next   = presence_reg;
        done            = 1'b0;
        rejected        = 1'b0;
        if (opcode == OP_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                slot_ticks_next = slot_inc;
            end
            case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_RST_LOW:
                begin
                    if (slot_inc >= RST_LOW_TICKS)
                    begin
                        phase_next      = PH_RST_WAIT;
                        slot_ticks_next = '0;
                    end
                end
                PH_RST_WAIT:
                begin
                    if (slot_inc >= RST_SAMPLE_TICKS)
                    begin
                        presence_next   = !line_level;
                        phase_next      = PH_RST_REC;
                        slot_ticks_next = '0;
                    end
                end
                PH_RST_REC:
                begin
                    if (slot_inc >= RST_REC_TICKS)
                    begin
                        phase_next      = PH_IDLE;
                        slot_ticks_next = '0;
                        done            = 1'b1;
                    end
                end
                PH_WRITE, PH_READ:
                begin
                    if (phase_reg == PH_READ && slot_inc == RD_SAMPLE_TICK)
                    begin
                        shift_byte_next = {line_level, shift_byte_reg[7:1]};
                    end
                    if (slot_inc >= ((phase_reg == PH_WRITE) ? WR_SLOT_TICKS : RD_SLOT_TICKS))
                    begin
                        slot_ticks_next = '0;
                        bit_index_next  = bit_index_reg + 1'b1;
                        if (bit_index_reg == 3'd7)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next      = PH_IDLE;
                    slot_ticks_next = '0;
                end
            endcase
        end
        else if (phase_reg != PH_IDLE)
        begin
            rejected = 1'b1;
        end
        else
        begin
            slot_ticks_next = '0;
            bit_index_next  = '0;
            case (opcode)
                OP_RESET:
                begin
                    phase_next    = PH_RST_LOW;
                    presence_next = 1'b0;
                end
                OP_WRITE:
                begin
                    phase_next      = PH_WRITE;
                    shift_byte_next = write_data;
                end
                default:
                begin
                    phase_next      = PH_READ;
                    shift_byte_next = '0;
                end
            endcase
        end
    end

    // line drive for the coming tick, from the updated state
    always_comb
    begin
        drive_low = 1'b0;
        case (phase_next)
            PH_RST_LOW:
            begin
                drive_low = 1'b1;
            end
            PH_WRITE:
            begin
                if (slot_ticks_next < SLOT_START_TICKS)
                begin
                    drive_low = 1'b1;
                end
                else if (slot_ticks_next < WR_LOW_END_TICKS
                         && !shift_byte_next[bit_index_next])
                begin
                    drive_low = 1'b1;
                end
            end
            PH_READ:
            begin
                drive_low = (slot_ticks_next < SLOT_START_TICKS);
            end
            default:
            begin
                drive_low = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, rejected, shift_byte_next, presence_next, done,
                              (phase_next != PH_IDLE), drive_low};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            slot_ticks_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            presence_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg      <= phase_next;
                slot_ticks_reg <= slot_ticks_next;
                bit_index_reg  <= bit_index_next;
                shift_byte_reg <= shift_byte_next;
                presence_reg   <= presence_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for one_wire_bus_master: directed and random command/tick streams,
// a cycle-free status predictor and a scoreboard on the result stream.
// Depends on ow_pkg (opcode_t, phase_t) and the one_wire_bus_master RTL.
module tb
    import ow_pkg::*;
();

    // bus timing in microsecond ticks
    localparam int RESET_LOW_US    = 480;
    localparam int PRESENCE_AT_US  = 70;
    localparam int RESET_RECOV_US  = 410;
    localparam int SLOT_LOW_US     = 2;
    localparam int WRITE_HOLD_US   = 60;
    localparam int WRITE_SLOT_US   = 64;
    localparam int READ_SAMPLE_US  = 12;
    localparam int READ_SLOT_US    = 62;
    localparam int WRITE_SEQ_US    = 8 * WRITE_SLOT_US;
    localparam int READ_SEQ_US     = 8 * READ_SLOT_US;

    localparam int LINE_LOW    = 0;
    localparam int LINE_RANDOM = 2;

    localparam int NOISE_ODDS  = 60;
    localparam int TAIL_TICKS  = 280;   // reset still in its low phase at the end
    localparam int QUIET_ITEMS = 200;   // no idling once this few items remain

    typedef struct packed {
        opcode_t    op;
        logic [7:0] wr_byte;
        logic       line;
    } bus_cmd_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] rd_byte;
        logic       rejected;
    } bus_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [7:0] write_data, [8] line_level, [15:9] zero
    logic [1:0]  s_axis_tuser = OP_TICK; // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [0] drive_low, [1] busy, [2] done, [3] presence,
                                        // [11:4] read_data, [12] rejected

    bus_cmd_t    cmd_queue[$];
    bus_status_t status_queue[$];
    bus_cmd_t    cmd_on_bus;
    int          src_gap = 0;
    int          sink_stall = 0;
    int          mismatches = 0;

    // predictor state
    phase_t      seq_phase = PH_IDLE;
    logic [9:0]  us_count = '0;
    logic [2:0]  bit_pos = '0;
    logic [7:0]  shift_reg = '0;
    logic        device_seen = 1'b0;

    one_wire_bus_master DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Advances the bus master by one command or tick and returns the status after it.
    function automatic bus_status_t predict_status(bus_cmd_t cmd);
        bus_status_t st;
        st = '0;
        if (cmd.op == OP_TICK)
        begin
            if (seq_phase != PH_IDLE)
            begin
                us_count = us_count + 10'd1;
                case (seq_phase)
                    PH_RST_LOW:
                        if (us_count >= RESET_LOW_US)
                        begin
                            seq_phase = PH_RST_WAIT;
                            us_count = '0;
                        end
                    PH_RST_WAIT:
                        if (us_count >= PRESENCE_AT_US)
                        begin
                            device_seen = ~cmd.line;
                            seq_phase = PH_RST_REC;
                            us_count = '0;
                        end
                    PH_RST_REC:
                        if (us_count >= RESET_RECOV_US)
                        begin
                            seq_phase = PH_IDLE;
                            us_count = '0;
                            st.done = 1'b1;
                        end
                    PH_WRITE, PH_READ:
                    begin
                        if (seq_phase == PH_READ && us_count == READ_SAMPLE_US)
                            shift_reg = {cmd.line, shift_reg[7:1]};
                        if (us_count >= (seq_phase == PH_WRITE ? WRITE_SLOT_US : READ_SLOT_US))
                        begin
                            us_count = '0;
                            if (bit_pos == 3'd7)
                            begin
                                bit_pos = '0;
                                seq_phase = PH_IDLE;
                                st.done = 1'b1;
                            end
                            else
                                bit_pos = bit_pos + 3'd1;
                        end
                    end
                    default:
                    begin
                        seq_phase = PH_IDLE;
                        us_count = '0;
                    end
                endcase
            end
        end
        else if (seq_phase != PH_IDLE)
            st.rejected = 1'b1;
        else
        begin
            us_count = '0;
            bit_pos = '0;
            case (cmd.op)
                OP_RESET:
                begin
                    seq_phase = PH_RST_LOW;
                    device_seen = 1'b0;
                end
                OP_WRITE:
                begin
                    seq_phase = PH_WRITE;
                    shift_reg = cmd.wr_byte;
                end
                default:
                begin
                    seq_phase = PH_READ;
                    shift_reg = '0;
                end
            endcase
        end

        case (seq_phase)
            PH_RST_LOW: st.drive_low = 1'b1;
            PH_WRITE:   st.drive_low = (us_count < SLOT_LOW_US) ||
                                       (us_count < SLOT_LOW_US + WRITE_HOLD_US &&
                                        !shift_reg[bit_pos]);
            PH_READ:    st.drive_low = (us_count < SLOT_LOW_US);
            default:    st.drive_low = 1'b0;
        endcase
        st.busy     = (seq_phase != PH_IDLE);
        st.presence = device_seen;
        st.rd_byte  = shift_reg;
        return st;
    endfunction

    task automatic add_cmd(opcode_t op, logic [7:0] wr_byte, logic line);
        bus_cmd_t c;
        c.op = op;
        c.wr_byte = wr_byte;
        c.line = line;
        cmd_queue.push_back(c);
    endtask

    // noise_odds: 1-in-N chance of a stray start command before each tick, 0 for none
    task automatic add_ticks(int count, int level, int noise_odds);
        for (int i = 0; i < count; i++)
        begin
            if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1)
                add_cmd(opcode_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
            add_cmd(OP_TICK, 8'($urandom),
                    level == LINE_RANDOM ? 1'($urandom) : 1'(level));
        end
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // source side
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                status_queue.push_back(predict_status(cmd_on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_queue.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (cmd_queue.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0)
                begin
                    src_gap = $urandom_range(0, 6);
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    cmd_on_bus = cmd_queue.pop_front();
                    s_axis_tdata  <= {7'b0, cmd_on_bus.line, cmd_on_bus.wr_byte};
                    s_axis_tuser  <= cmd_on_bus.op;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // sink side
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (status_queue.size() == 0)
                begin
                    $error("result transaction with no expected status: %04h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    bus_status_t exp_st;
                    exp_st = status_queue.pop_front();
                    check_field("drive_low", exp_st.drive_low, m_axis_tdata[0]);
                    check_field("busy_res",  exp_st.busy,      m_axis_tdata[1]);
                    check_field("done_res",  exp_st.done,      m_axis_tdata[2]);
                    check_field("presence",  exp_st.presence,  m_axis_tdata[3]);
                    check_field("read_data", exp_st.rd_byte,   m_axis_tdata[11:4]);
                    check_field("rejected",  exp_st.rejected,  m_axis_tdata[12]);
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (cmd_queue.size() > QUIET_ITEMS && $urandom_range(0, 5) == 0)
            begin
                sink_stall = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        // idle ticks, then a full write and a full read with starts that land while busy,
        // then a reset that is still pulling the line low when the run ends
        add_cmd(OP_TICK, 8'h00, 1'b0);
        add_cmd(OP_TICK, 8'hFF, 1'b1);
        add_cmd(OP_WRITE, 8'h3C, 1'b1);
        add_cmd(OP_READ, 8'h00, 1'b0);
        add_cmd(OP_RESET, 8'hA5, 1'b1);
        add_ticks(WRITE_SEQ_US, LINE_RANDOM, NOISE_ODDS);
        add_cmd(OP_READ, 8'hFF, 1'b1);
        add_cmd(OP_WRITE, 8'h5A, 1'b0);
        add_ticks(READ_SEQ_US, LINE_RANDOM, NOISE_ODDS);
        add_cmd(OP_TICK, 8'h81, 1'b0);
        add_cmd(OP_RESET, 8'h00, 1'b0);
        add_ticks(TAIL_TICKS, LINE_LOW, NOISE_ODDS);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (cmd_queue.size() != 0 || s_axis_tvalid || status_queue.size() != 0);
        repeat (4) @(posedge clk);

        if (mismatches == 0 && status_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ow_pkg.sv
hdl/one_wire_bus_master.sv
dv/tb.sv
